/* hw/rtl/lds_pkg.sv */
// Package for the 2x2 linear system solver: width constants and the
// sideband struct that travels with each item. No dependencies.
package lds_pkg;

	// Default operand width and output fraction bits.
	localparam int DataWidthDef   = 16;
	localparam int OutFracBitsDef = 16;

	// Result element width is fixed.
	localparam int OutWidth = 32;

	// Control bits that ride alongside each item through the pipeline.
	typedef struct packed {
		logic valid;
		logic neg0;
		logic neg1;
		logic sing;
	} lds_side_t;

endpackage

/* hw/rtl/lds_front.sv */
// Front end of the solver: products, determinant and numerators, then
// magnitudes and signs ready for the divider chain. Uses lds_pkg.
module lds_front #(
	parameter int DATA_WIDTH    = lds_pkg::DataWidthDef,
	parameter int OUT_FRAC_BITS = lds_pkg::OutFracBitsDef
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic signed [DATA_WIDTH-1:0]            a00,
	input  logic signed [DATA_WIDTH-1:0]            a01,
	input  logic signed [DATA_WIDTH-1:0]            a10,
	input  logic signed [DATA_WIDTH-1:0]            a11,
	input  logic signed [DATA_WIDTH-1:0]            b0,
	input  logic signed [DATA_WIDTH-1:0]            b1,
	output lds_pkg::lds_side_t                      side,
	output logic [2*DATA_WIDTH-1:0]                 divisor,
	output logic [2*DATA_WIDTH+OUT_FRAC_BITS-1:0]   dvd0,
	output logic [2*DATA_WIDTH+OUT_FRAC_BITS-1:0]   dvd1
);
	localparam int PW = 2 * DATA_WIDTH;
	localparam int SW = PW + 1;
	localparam int MW = PW;
	localparam int QW = MW + OUT_FRAC_BITS;

	logic              v_s1, v_s2, v_s3;
	logic signed [PW-1:0] pad_s1, pbc_s1, p0a_s1, p0b_s1, p1a_s1, p1b_s1;
	logic signed [SW-1:0] det_s2, n0_s2, n1_s2;
	logic [MW-1:0]        mdet_s3, mn0_s3, mn1_s3;
	logic                 neg0_s3, neg1_s3, sing_s3;
	logic [SW-1:0]        adet, an0, an1;

	// Valid bits of the three front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Absolute values of the exact differences.
	always_comb begin
		adet = det_s2[SW-1] ? SW'(-det_s2) : SW'(det_s2);
		an0  = n0_s2[SW-1]  ? SW'(-n0_s2)  : SW'(n0_s2);
		an1  = n1_s2[SW-1]  ? SW'(-n1_s2)  : SW'(n1_s2);
	end

	// Stage one forms the six products, stage two the differences,
	// stage three the magnitudes and quotient signs.
	always_ff @(posedge clk) begin
		if (en) begin
			pad_s1  <= PW'(a00) * PW'(a11);
			pbc_s1  <= PW'(a10) * PW'(a01);
			p0a_s1  <= PW'(a11) * PW'(b0);
			p0b_s1  <= PW'(a01) * PW'(b1);
			p1a_s1  <= PW'(a00) * PW'(b1);
			p1b_s1  <= PW'(a10) * PW'(b0);
			det_s2  <= SW'(pad_s1) - SW'(pbc_s1);
			n0_s2   <= SW'(p0a_s1) - SW'(p0b_s1);
			n1_s2   <= SW'(p1a_s1) - SW'(p1b_s1);
			mdet_s3 <= adet[MW-1:0];
			mn0_s3  <= an0[MW-1:0];
			mn1_s3  <= an1[MW-1:0];
			neg0_s3 <= n0_s2[SW-1] ^ det_s2[SW-1];
			neg1_s3 <= n1_s2[SW-1] ^ det_s2[SW-1];
			sing_s3 <= (det_s2 == '0);
		end
	end

	assign side.valid = v_s3;
	assign side.neg0  = neg0_s3;
	assign side.neg1  = neg1_s3;
	assign side.sing  = sing_s3;
	assign divisor    = mdet_s3;
	assign dvd0       = QW'(mn0_s3) << OUT_FRAC_BITS;
	assign dvd1       = QW'(mn1_s3) << OUT_FRAC_BITS;
endmodule

/* hw/rtl/lds_div_cell.sv */
// One restoring-division cell: produces one quotient bit for both lanes
// and hands remainder, dividend and quotient to the next cell. Uses lds_pkg.
module lds_div_cell #(
	parameter int MW = 32,
	parameter int QW = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  lds_pkg::lds_side_t side_i,
	input  logic [MW-1:0]      div_i,
	input  logic [MW-1:0]      rem0_i,
	input  logic [MW-1:0]      rem1_i,
	input  logic [QW-1:0]      dvd0_i,
	input  logic [QW-1:0]      dvd1_i,
	input  logic [QW-1:0]      quo0_i,
	input  logic [QW-1:0]      quo1_i,
	output lds_pkg::lds_side_t side_o,
	output logic [MW-1:0]      div_o,
	output logic [MW-1:0]      rem0_o,
	output logic [MW-1:0]      rem1_o,
	output logic [QW-1:0]      dvd0_o,
	output logic [QW-1:0]      dvd1_o,
	output logic [QW-1:0]      quo0_o,
	output logic [QW-1:0]      quo1_o
);
	logic [MW:0] trial0, trial1, diff0, diff1;
	logic        ge0, ge1;

	// Shift in the next dividend bit and try a subtraction.
	always_comb begin
		trial0 = {rem0_i, dvd0_i[QW-1]};
		trial1 = {rem1_i, dvd1_i[QW-1]};
		diff0  = trial0 - {1'b0, div_i};
		diff1  = trial1 - {1'b0, div_i};
		ge0    = (trial0 >= {1'b0, div_i});
		ge1    = (trial1 >= {1'b0, div_i});
	end

	// Control state of the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_o <= '0;
		end else if (en) begin
			side_o <= side_i;
		end
	end

	// Data handed to the neighbor.
	always_ff @(posedge clk) begin
		if (en) begin
			div_o  <= div_i;
			rem0_o <= ge0 ? diff0[MW-1:0] : trial0[MW-1:0];
			rem1_o <= ge1 ? diff1[MW-1:0] : trial1[MW-1:0];
			dvd0_o <= {dvd0_i[QW-2:0], 1'b0};
			dvd1_o <= {dvd1_i[QW-2:0], 1'b0};
			quo0_o <= {quo0_i[QW-2:0], ge0};
			quo1_o <= {quo1_i[QW-2:0], ge1};
		end
	end
endmodule

/* hw/rtl/linear_system_2x2_solver.sv */
// Top level of the 2x2 linear system solver: front end, divider cell
// chain and output register. Uses lds_pkg, lds_front, lds_div_cell.
//
// Usage: an item carries a 2x2 matrix a00..a11 and a right-hand side b0, b1,
// all signed fixed point. It is taken when in_valid and in_ready are both
// high. The result x0, x1 (signed, OUT_FRAC_BITS fraction bits, saturated),
// singular and overflow appears with out_valid and is taken on out_ready.
// Three front stages form products and differences, one chain cell per
// quotient bit follows, and then the output register. One item is accepted
// per cycle while the pipeline is not stalled.
// The whole pipeline advances together; while a result waits on a stalled
// receiver, the pipeline holds and in_ready is low, and it resumes the
// cycle the result is taken. Reset clears all valid bits, so the block is
// empty and ready right after reset; no clearing pass is needed.
module linear_system_2x2_solver #(
	parameter int DATA_WIDTH    = lds_pkg::DataWidthDef,
	parameter int OUT_FRAC_BITS = lds_pkg::OutFracBitsDef
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [DATA_WIDTH-1:0]        a00,
	input  logic signed [DATA_WIDTH-1:0]        a01,
	input  logic signed [DATA_WIDTH-1:0]        a10,
	input  logic signed [DATA_WIDTH-1:0]        a11,
	input  logic signed [DATA_WIDTH-1:0]        b0,
	input  logic signed [DATA_WIDTH-1:0]        b1,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [lds_pkg::OutWidth-1:0] x0,
	output logic signed [lds_pkg::OutWidth-1:0] x1,
	output logic                                singular,
	output logic                                overflow
);
	localparam int MW = 2 * DATA_WIDTH;
	localparam int QW = MW + OUT_FRAC_BITS;
	localparam int OW = lds_pkg::OutWidth;
	localparam int QE = ((QW > OW) ? QW : OW) + 1;
	localparam logic [QE-1:0] MaxPos = (QE'(1) << (OW - 1)) - QE'(1);
	localparam logic [QE-1:0] MaxNeg = QE'(1) << (OW - 1);

	logic en;
	lds_pkg::lds_side_t side [0:QW];
	logic [MW-1:0] dv   [0:QW];
	logic [MW-1:0] rem0 [0:QW];
	logic [MW-1:0] rem1 [0:QW];
	logic [QW-1:0] dvd0 [0:QW];
	logic [QW-1:0] dvd1 [0:QW];
	logic [QW-1:0] quo0 [0:QW];
	logic [QW-1:0] quo1 [0:QW];

	logic [QE-1:0] q0e, q1e;
	logic          sat0, sat1;
	logic [OW-1:0] r0, r1;
	logic          out_valid_q, sing_q, ovf_q;
	logic [OW-1:0] x0_q, x1_q;

	// The pipeline moves whenever the output register is free or drains.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	lds_front #(
		.DATA_WIDTH   (DATA_WIDTH),
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(in_valid),
		.a00     (a00),
		.a01     (a01),
		.a10     (a10),
		.a11     (a11),
		.b0      (b0),
		.b1      (b1),
		.side    (side[0]),
		.divisor (dv[0]),
		.dvd0    (dvd0[0]),
		.dvd1    (dvd1[0])
	);

	assign rem0[0] = '0;
	assign rem1[0] = '0;
	assign quo0[0] = '0;
	assign quo1[0] = '0;

	// One cell per quotient bit, most significant first.
	for (genvar k = 0; k < QW; k++) begin : g_cell
		lds_div_cell #(
			.MW(MW),
			.QW(QW)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.side_i(side[k]),
			.div_i (dv[k]),
			.rem0_i(rem0[k]),
			.rem1_i(rem1[k]),
			.dvd0_i(dvd0[k]),
			.dvd1_i(dvd1[k]),
			.quo0_i(quo0[k]),
			.quo1_i(quo1[k]),
			.side_o(side[k+1]),
			.div_o (dv[k+1]),
			.rem0_o(rem0[k+1]),
			.rem1_o(rem1[k+1]),
			.dvd0_o(dvd0[k+1]),
			.dvd1_o(dvd1[k+1]),
			.quo0_o(quo0[k+1]),
			.quo1_o(quo1[k+1])
		);
	end

	// Apply signs and saturate the quotient magnitudes.
	always_comb begin
		q0e  = QE'(quo0[QW]);
		q1e  = QE'(quo1[QW]);
		sat0 = side[QW].neg0 ? (q0e > MaxNeg) : (q0e > MaxPos);
		sat1 = side[QW].neg1 ? (q1e > MaxNeg) : (q1e > MaxPos);
		if (sat0) begin
			r0 = side[QW].neg0 ? MaxNeg[OW-1:0] : MaxPos[OW-1:0];
		end else begin
			r0 = side[QW].neg0 ? (OW'(0) - q0e[OW-1:0]) : q0e[OW-1:0];
		end
		if (sat1) begin
			r1 = side[QW].neg1 ? MaxNeg[OW-1:0] : MaxPos[OW-1:0];
		end else begin
			r1 = side[QW].neg1 ? (OW'(0) - q1e[OW-1:0]) : q1e[OW-1:0];
		end
	end

	// Output register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= side[QW].valid;
		end
	end

	// Output register payload; a singular system reads as zeros.
	always_ff @(posedge clk) begin
		if (en) begin
			sing_q <= side[QW].sing;
			ovf_q  <= !side[QW].sing && (sat0 || sat1);
			x0_q   <= side[QW].sing ? '0 : r0;
			x1_q   <= side[QW].sing ? '0 : r1;
		end
	end

	assign out_valid = out_valid_q;
	assign x0        = x0_q;
	assign x1        = x1_q;
	assign singular  = sing_q;
	assign overflow  = ovf_q;
endmodule
